// File: hdl/urpw_pkg.sv
// Shared types and constants of the user range page walk checker.
`timescale 1ns / 1ps
package urpw_pkg;

  localparam int DEF_TABLE_FRAMES  = 16;
  localparam int ENTRIES_PER_TABLE = 512;
  localparam int MAX_LENGTH        = 65536;
  localparam int FRAME_W           = 40;
  localparam int CFG_DATA_W        = 40;
  localparam int CFG_INDEX_W       = 1;

  localparam logic [CFG_INDEX_W-1:0] CFG_ROOT_FRAME = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_STORE_BASE = 1'b1;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_CHECK = 1'b1;

  // Page table entry bits
  localparam int PTE_PRESENT  = 0;
  localparam int PTE_WRITABLE = 1;
  localparam int PTE_USER     = 2;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ZERO_ROOT = 3'd1,
    ST_NULL      = 3'd2,
    ST_WRAP      = 3'd3,
    ST_NONCANON  = 3'd4,
    ST_DENIED    = 3'd5
  } urpw_status_t;

endpackage

// File: hdl/urpw_ifs.sv
// Request and response channel interfaces of the user range page walk checker.
`timescale 1ns / 1ps
interface urpw_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [12:0] word_index;
  logic [63:0] word_value;
  logic [63:0] start_addr;
  logic [16:0] length;
  logic        want_write;

  modport source (output valid, func, word_index, word_value, start_addr, length,
                  want_write, input ready);
  modport sink (input valid, func, word_index, word_value, start_addr, length,
                want_write, output ready);
endinterface

interface urpw_rsp_if import urpw_pkg::*; ();
  logic         valid;
  logic         ready;
  logic         allowed;
  urpw_status_t status;

  modport source (output valid, allowed, status, input ready);
  modport sink (input valid, allowed, status, output ready);
endinterface

// File: hdl/user_range_page_walk_check_unit.sv
// Top level of the user range page walk checker.
`timescale 1ns / 1ps
// Holds TABLE_FRAMES page-table frames of 512 words in one store and answers
// one item at a time: a table word write, or a check of whether a user virtual
// range may be read (or written) through a four-level walk. After reset the
// store is zeroed by a sweep over all TABLE_FRAMES * 512 words, one word a
// cycle, during which no item is taken (configuration writes still are). A
// check that walks the tables needs one read per level from the single store
// read port, and a 64 KiB range touches up to 17 pages. A new item is taken
// while the previous result still waits in the output register.
module user_range_page_walk_check_unit
  import urpw_pkg::*;
#(
  parameter int TABLE_FRAMES = DEF_TABLE_FRAMES
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  urpw_req_if.sink               req,
  urpw_rsp_if.source             rsp
);

  localparam int FW         = $clog2(TABLE_FRAMES);
  localparam int AW         = FW + $clog2(ENTRIES_PER_TABLE);
  localparam int StoreWords = TABLE_FRAMES * ENTRIES_PER_TABLE;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PRE,
    S_WALK,
    S_FINISH
  } state_t;

  state_t               state;
  logic [AW-1:0]        clr_addr;
  logic [FRAME_W-1:0]   root_frame;
  logic [FRAME_W-1:0]   store_base_frame;
  logic [63:0]          start_addr;
  logic [16:0]          length;
  logic                 want_write;
  logic [34:0]          vpn;
  logic [34:0]          last_vpn;
  logic [1:0]           lvl;
  urpw_status_t         res_status;
  logic                 out_valid;
  logic                 out_allowed;
  urpw_status_t         out_status;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [63:0]          ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [63:0]          ram_rdata;

  logic [FW:0]          root_w;
  logic [FW:0]          next_w;
  logic [34:0]          vpn_inc;
  logic [16:0]          len_m1;
  logic [64:0]          end_sum;
  logic [63:0]          end_addr;
  logic                 noncanon;
  logic                 too_long;
  logic                 pu_ok;
  logic                 req_fire;

  // {in window, frame offset within the store}
  function automatic logic [FW:0] frame_window(input logic [FRAME_W-1:0] fr,
                                               input logic [FRAME_W-1:0] base);
    logic [FRAME_W:0] diff;
    logic             ok;
    diff = {1'b0, fr} - {1'b0, base};
    ok   = !diff[FRAME_W] && (diff[FRAME_W-1:0] < FRAME_W'(TABLE_FRAMES));
    return {ok, diff[FW-1:0]};
  endfunction

  function automatic logic [8:0] lvl_idx(input logic [34:0] v, input logic [1:0] l);
    logic [8:0] idx;
    case (l)
      2'd0:    idx = {1'b0, v[34:27]};
      2'd1:    idx = v[26:18];
      2'd2:    idx = v[17:9];
      default: idx = v[8:0];
    endcase
    return idx;
  endfunction

  assign req_fire = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);

  assign rsp.valid   = out_valid;
  assign rsp.allowed = out_allowed;
  assign rsp.status  = out_status;

  assign root_w   = frame_window(root_frame, store_base_frame);
  assign next_w   = frame_window(ram_rdata[51:12], store_base_frame);
  assign vpn_inc  = vpn + 35'd1;
  assign pu_ok    = ram_rdata[PTE_PRESENT] && ram_rdata[PTE_USER];

  assign len_m1   = length - 17'd1;
  assign end_sum  = {1'b0, start_addr} + {48'b0, len_m1};
  assign end_addr = end_sum[63:0];
  assign noncanon = (start_addr[63:47] != '0) || (end_addr[63:47] != '0);
  assign too_long = {15'b0, length} > 32'(MAX_LENGTH);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(req.word_index);
    ram_wdata = req.word_value;
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else if (req_fire && req.func == FUNC_WRITE &&
                 32'(req.word_index) < 32'(StoreWords)) begin
      ram_we = 1'b1;
    end
  end

  // Read address: first level of the first page, the next level of the walk, or the first level of the next page
  always_comb begin
    ram_raddr = {root_w[FW-1:0], lvl_idx(start_addr[46:12], 2'd0)};
    if (state == S_WALK) begin
      if (lvl != 2'd3) begin
        ram_raddr = {next_w[FW-1:0], lvl_idx(vpn, lvl + 2'd1)};
      end else begin
        ram_raddr = {root_w[FW-1:0], lvl_idx(vpn_inc, 2'd0)};
      end
    end
  end

  urpw_ram #(
    .WIDTH (64),
    .DEPTH (StoreWords)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_CLEAR;
      clr_addr         <= '0;
      root_frame       <= '0;
      store_base_frame <= '0;
      lvl              <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ROOT_FRAME: root_frame       <= cfg_wdata;
          CFG_STORE_BASE: store_base_frame <= cfg_wdata;
          default: ;
        endcase
      end

      // in S_FINISH the output register is reloaded below instead
      if (rsp.valid && rsp.ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(StoreWords - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_fire) begin
            start_addr <= req.start_addr;
            length     <= req.length;
            want_write <= req.want_write;
            if (req.func == FUNC_WRITE) begin
              res_status <= ST_OK;
              state      <= S_FINISH;
            end else begin
              state <= S_PRE;
            end
          end
        end
        S_PRE: begin
          vpn      <= start_addr[46:12];
          last_vpn <= end_addr[46:12];
          lvl      <= 2'd0;
          if (root_frame == '0) begin
            res_status <= ST_ZERO_ROOT;
            state      <= S_FINISH;
          end else if (length == '0) begin
            res_status <= ST_OK;
            state      <= S_FINISH;
          end else if (start_addr == '0) begin
            res_status <= ST_NULL;
            state      <= S_FINISH;
          end else if (end_sum[64]) begin
            res_status <= ST_WRAP;
            state      <= S_FINISH;
          end else if (noncanon) begin
            res_status <= ST_NONCANON;
            state      <= S_FINISH;
          end else if (too_long || !root_w[FW]) begin
            res_status <= ST_DENIED;
            state      <= S_FINISH;
          end else begin
            // first-level read of the first page is already issued
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (!pu_ok) begin
            res_status <= ST_DENIED;
            state      <= S_FINISH;
          end else if (lvl != 2'd3) begin
            if (!next_w[FW]) begin
              res_status <= ST_DENIED;
              state      <= S_FINISH;
            end else begin
              lvl <= lvl + 2'd1;
            end
          end else if (want_write && !ram_rdata[PTE_WRITABLE]) begin
            res_status <= ST_DENIED;
            state      <= S_FINISH;
          end else if (vpn == last_vpn) begin
            res_status <= ST_OK;
            state      <= S_FINISH;
          end else begin
            // advance to the next page; its first-level read is issued now
            vpn <= vpn_inc;
            lvl <= 2'd0;
          end
        end
        S_FINISH: begin
          // hold the result until the output register is free
          if (!out_valid || rsp.ready) begin
            out_valid   <= 1'b1;
            out_allowed <= (res_status == ST_OK);
            out_status  <= res_status;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hdl/urpw_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module urpw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
